>>> hw/rtl/wbmu_pkg.sv
// Package for the wide bit-manipulation unit: operation codes, request and
// result structs, width constants, opcode helper functions. No dependencies.

package wbmu_pkg;

	localparam int DATA_W    = 64;
	localparam int SHAMT_W   = 8;
	localparam int FSTART_W  = 6;
	localparam int FWIDTH_W  = 7;
	localparam int OPCODE_W  = 4;
	localparam int SHIDX_W   = $clog2(DATA_W);
	localparam int FEND_W    = FWIDTH_W + 1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_AND     = 4'd0,
		OP_OR      = 4'd1,
		OP_XOR     = 4'd2,
		OP_TEST    = 4'd3,
		OP_NOT     = 4'd4,
		OP_LSHIFT  = 4'd5,
		OP_RSHIFT  = 4'd6,
		OP_ARSHIFT = 4'd7,
		OP_LROT    = 4'd8,
		OP_RROT    = 4'd9,
		OP_EXTRACT = 4'd10,
		OP_REPLACE = 4'd11
	} op_t;

	typedef struct packed {
		logic [OPCODE_W-1:0]       op;
		logic [DATA_W-1:0]         a;
		logic [DATA_W-1:0]         b;
		logic signed [SHAMT_W-1:0] shamt;
		logic [FSTART_W-1:0]       fstart;
		logic [FWIDTH_W-1:0]       fwidth;
		logic                      last;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              flag;
		logic              status;
	} res_t;

	function automatic logic is_reduce_op(input logic [OPCODE_W-1:0] op);
		return (op == OP_AND) || (op == OP_OR) || (op == OP_XOR) || (op == OP_TEST);
	endfunction

	function automatic logic is_known_op(input logic [OPCODE_W-1:0] op);
		return op <= OP_REPLACE;
	endfunction

endpackage

>>> hw/rtl/wide_bit_manipulation_unit.sv
// Wide bit-manipulation unit, 64-bit datapath, top level.
// A request passes through the request register and then the result register before
// out_valid rises. Throughput: one request per cycle; while a result waits, one more
// request is taken into the request register and then the input stalls. Non-last
// reduction operands and unknown codes give no result. Reset (arst_n low,
// asynchronous): pipeline empty, no run open.

module wide_bit_manipulation_unit import wbmu_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [OPCODE_W-1:0]        req_type,
	input  logic [DATA_W-1:0]          operand_a,
	input  logic [DATA_W-1:0]          operand_b,
	input  logic signed [SHAMT_W-1:0]  shift_amount,
	input  logic [FSTART_W-1:0]        field_start,
	input  logic [FWIDTH_W-1:0]        field_width,
	input  logic                       last_operand,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [DATA_W-1:0]          result_value,
	output logic                       test_flag,
	output logic                       status
);

	logic v_s1;
	req_t req_s1;
	logic v_s2;
	res_t res_s2;

	logic s2_open;
	logic advance;
	logic accept;
	logic emit;
	res_t alu_res;
	res_t red_res;
	res_t sel_res;

	// Handshake: stage 1 moves on when the result register is free or drains
	assign s2_open  = !v_s2 || !out_stall;
	assign advance  = v_s1 && s2_open;
	assign in_stall = v_s1 && !s2_open;
	assign accept   = in_valid && !in_stall;

	// Hold the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.op     <= req_type;
			req_s1.a      <= operand_a;
			req_s1.b      <= operand_b;
			req_s1.shamt  <= shift_amount;
			req_s1.fstart <= field_start;
			req_s1.fwidth <= field_width;
			req_s1.last   <= last_operand;
		end
	end

	wbmu_alu u_alu (
		.req (req_s1),
		.res (alu_res)
	);

	wbmu_reduce u_reduce (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.res     (red_res)
	);

	// Pick the result source and decide whether the request produces one
	always_comb begin
		if (is_reduce_op(req_s1.op)) begin
			sel_res = red_res;
			emit    = req_s1.last;
		end else begin
			sel_res = alu_res;
			emit    = is_known_op(req_s1.op);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_open) begin
			v_s2 <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s2_open) begin
			res_s2 <= sel_res;
		end
	end

	assign out_valid    = v_s2;
	assign result_value = res_s2.value;
	assign test_flag    = res_s2.flag;
	assign status       = res_s2.status;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2)
		else $error("request side stalled with nothing to drain");

	a_flag_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(test_flag && status))
		else $error("test flag and field error raised together");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> result_value == '0)
		else $error("field error with nonzero result");

endmodule

>>> hw/rtl/wbmu_alu.sv
// Per-request datapath: NOT, shifts, rotates, field extract and replace.
// Purely combinational; depends on wbmu_pkg.

module wbmu_alu import wbmu_pkg::*; (
	input  req_t req,
	output res_t res
);

	logic                        neg;
	logic [SHAMT_W-1:0]          mag;
	logic                        shl;
	logic                        fill;
	logic                        big;
	logic signed [DATA_W:0]      ext;
	logic signed [DATA_W:0]      sr_w;
	logic [DATA_W-1:0]           sh_res;
	logic [SHIDX_W-1:0]          rot_k;
	logic [2*DATA_W-1:0]         rot_w;
	logic [FEND_W-1:0]           fend;
	logic                        fbad;
	logic [DATA_W-1:0]           fmask;
	logic [DATA_W-1:0]           extract_v;
	logic [DATA_W-1:0]           replace_v;

	// Resolve shift direction and magnitude from the signed count
	always_comb begin
		neg  = req.shamt[SHAMT_W-1];
		mag  = neg ? SHAMT_W'(-req.shamt) : SHAMT_W'(req.shamt);
		big  = mag >= SHAMT_W'(DATA_W);
		shl  = 1'b0;
		fill = 1'b0;
		case (req.op)
			OP_LSHIFT: begin
				shl = !neg;
			end
			OP_RSHIFT: begin
				shl = neg;
			end
			OP_ARSHIFT: begin
				shl  = neg;
				fill = req.a[DATA_W-1] & !neg;
			end
			default: begin
				shl = 1'b0;
			end
		endcase
	end

	// Shift with sign fill; out-of-range counts saturate to the fill pattern
	always_comb begin
		ext  = {fill, req.a};
		sr_w = ext >>> mag[SHIDX_W-1:0];
		if (big) begin
			sh_res = {DATA_W{fill}};
		end else if (shl) begin
			sh_res = req.a << mag[SHIDX_W-1:0];
		end else begin
			sh_res = sr_w[DATA_W-1:0];
		end
	end

	// Rotate left by count modulo width; right rotates negate the count
	always_comb begin
		if (req.op == OP_RROT) begin
			rot_k = -req.shamt[SHIDX_W-1:0];
		end else begin
			rot_k = req.shamt[SHIDX_W-1:0];
		end
		rot_w = {req.a, req.a} << rot_k;
	end

	// Field mask and range check
	always_comb begin
		fend      = FEND_W'(req.fstart) + FEND_W'(req.fwidth);
		fbad      = (req.fwidth == '0) || (fend > FEND_W'(DATA_W));
		fmask     = ~({DATA_W{1'b1}} << req.fwidth);
		extract_v = (req.a >> req.fstart) & fmask;
		replace_v = (req.a & ~(fmask << req.fstart)) | ((req.b & fmask) << req.fstart);
	end

	// Select the result for the operation
	always_comb begin
		res = '0;
		case (req.op)
			OP_NOT: begin
				res.value = ~req.a;
			end
			OP_LSHIFT, OP_RSHIFT, OP_ARSHIFT: begin
				res.value = sh_res;
			end
			OP_LROT, OP_RROT: begin
				res.value = rot_w[2*DATA_W-1:DATA_W];
			end
			OP_EXTRACT: begin
				res.status = fbad;
				res.value  = fbad ? '0 : extract_v;
			end
			OP_REPLACE: begin
				res.status = fbad;
				res.value  = fbad ? '0 : replace_v;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

>>> hw/rtl/wbmu_reduce.sv
// Run accumulator for AND/OR/XOR/TEST reductions.
// Holds the partial result across requests; depends on wbmu_pkg.

module wbmu_reduce import wbmu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  req_t req,
	output res_t res
);

	logic [DATA_W-1:0] acc_q;
	logic              run_q;
	logic [DATA_W-1:0] acc_next;
	logic              fold;

	// Fold the operand with its own operation; a fresh run takes it as is
	always_comb begin
		fold = advance && is_reduce_op(req.op);
		if (!run_q) begin
			acc_next = req.a;
		end else begin
			case (req.op)
				OP_OR: begin
					acc_next = acc_q | req.a;
				end
				OP_XOR: begin
					acc_next = acc_q ^ req.a;
				end
				default: begin
					acc_next = acc_q & req.a;
				end
			endcase
		end
		res.value  = acc_next;
		res.flag   = (req.op == OP_TEST) && (acc_next != '0);
		res.status = 1'b0;
	end

	// Advance the run; the last operand closes it and clears the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			run_q <= 1'b0;
		end else if (fold) begin
			if (req.last) begin
				acc_q <= '0;
				run_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				run_q <= 1'b1;
			end
		end
	end

	a_idle_acc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> acc_q == '0)
		else $error("accumulator not clear outside a run");

	a_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		fold && req.last |=> !run_q)
		else $error("last operand did not close the run");

	a_nonlast_opens_run: assert property (@(posedge clk) disable iff (!arst_n)
		fold && !req.last |=> run_q)
		else $error("run not open after a non-last operand");

endmodule

>>> bench/tb_wide_bit_manipulation_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for wide_bit_manipulation_unit: directed and random requests are
// predicted by a scoreboard class and every result is compared field by field.
// Depends on wbmu_pkg and the unit's RTL.

module tb_wide_bit_manipulation_unit;
	import wbmu_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 48;
	localparam int PHASE_ITEMS  = 130;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd12;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;
	localparam logic [DATA_W-1:0]   ALL_ONES     = '1;
	localparam logic [DATA_W-1:0]   TOP_ONLY     = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              flag;
		logic              status;
	} bitop_result_t;

	// Fold state and expected results of the unit
	class bitop_scoreboard;
		bitop_result_t     awaited_results[$];
		logic [DATA_W-1:0] run_acc;
		bit                run_open;
		int                requests_seen;
		int                results_checked;
		int                mismatches;

		function new();
			run_acc         = '0;
			run_open        = 1'b0;
			requests_seen   = 0;
			results_checked = 0;
			mismatches      = 0;
		endfunction

		// Positive count moves left, negative moves right; 64 or more clears
		static function logic [DATA_W-1:0] shift_by(logic [DATA_W-1:0] v, int cnt);
			if (cnt < 0)
				return (-cnt >= DATA_W) ? '0 : (v >> (-cnt));
			return (cnt >= DATA_W) ? '0 : (v << cnt);
		endfunction

		static function logic [DATA_W-1:0] arith_shift_by(logic [DATA_W-1:0] v, int cnt);
			logic signed [DATA_W-1:0] sv;
			sv = v;
			if (cnt < 0 || !v[DATA_W-1])
				return shift_by(v, -cnt);
			if (cnt >= DATA_W)
				return ALL_ONES;
			return sv >>> cnt;
		endfunction

		static function logic [DATA_W-1:0] rotate_by(logic [DATA_W-1:0] v, int cnt);
			int k;
			k = cnt % DATA_W;
			if (k < 0)
				k += DATA_W;
			if (k == 0)
				return v;
			return (v << k) | (v >> (DATA_W - k));
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// Advance the fold state and queue the result this request causes, if any
		function void note_request(req_t r);
			bitop_result_t     res;
			logic [DATA_W-1:0] acc;
			logic [DATA_W-1:0] mask;
			int                sh;
			requests_seen++;
			if (r.op > OP_REPLACE)
				return;
			sh         = int'(r.shamt);
			res.value  = '0;
			res.flag   = 1'b0;
			res.status = 1'b0;
			case (r.op)
				OP_AND, OP_OR, OP_XOR, OP_TEST: begin
					if (!run_open)
						acc = r.a;
					else if (r.op == OP_OR)
						acc = run_acc | r.a;
					else if (r.op == OP_XOR)
						acc = run_acc ^ r.a;
					else
						acc = run_acc & r.a;
					if (!r.last) begin
						run_acc  = acc;
						run_open = 1'b1;
						return;
					end
					run_acc   = '0;
					run_open  = 1'b0;
					res.value = acc;
					res.flag  = (r.op == OP_TEST) && (acc != '0);
				end
				OP_NOT:     res.value = ~r.a;
				OP_LSHIFT:  res.value = shift_by(r.a, sh);
				OP_RSHIFT:  res.value = shift_by(r.a, -sh);
				OP_ARSHIFT: res.value = arith_shift_by(r.a, sh);
				OP_LROT:    res.value = rotate_by(r.a, sh);
				OP_RROT:    res.value = rotate_by(r.a, -sh);
				default: begin
					// Field ops: flag a field that is empty or runs past the top bit
					if (r.fwidth == 0 || int'(r.fstart) + int'(r.fwidth) > DATA_W) begin
						res.status = 1'b1;
					end else begin
						mask = (r.fwidth >= DATA_W) ? ALL_ONES
							: (DATA_W'(1) << r.fwidth) - DATA_W'(1);
						if (r.op == OP_EXTRACT)
							res.value = (r.a >> r.fstart) & mask;
						else
							res.value = (r.a & ~(mask << r.fstart)) | ((r.b & mask) << r.fstart);
					end
				end
			endcase
			awaited_results.push_back(res);
		endfunction

		// Compare one result with the oldest expectation
		function void check_result(logic [DATA_W-1:0] value, logic flag, logic st_bit);
			bitop_result_t want;
			results_checked++;
			if (awaited_results.size() == 0) begin
				$error("result with none awaited: result_value=%h test_flag=%b status=%b",
					value, flag, st_bit);
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			if (value !== want.value) begin
				$error("result_value: expected %h, got %h", want.value, value);
				mismatches++;
			end
			if (flag !== want.flag) begin
				$error("test_flag: expected %b, got %b", want.flag, flag);
				mismatches++;
			end
			if (st_bit !== want.status) begin
				$error("status: expected %b, got %b", want.status, st_bit);
				mismatches++;
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n          = 1'b0;
	logic                      in_valid        = 1'b0;
	logic                      in_stall;
	logic [OPCODE_W-1:0]       req_type        = '0;
	logic [DATA_W-1:0]         operand_a       = '0;
	logic [DATA_W-1:0]         operand_b       = '0;
	logic signed [SHAMT_W-1:0] shift_amount    = '0;
	logic [FSTART_W-1:0]       field_start     = '0;
	logic [FWIDTH_W-1:0]       field_width     = '0;
	logic                      last_operand    = 1'b0;
	logic                      out_valid;
	logic                      out_stall       = 1'b0;
	logic [DATA_W-1:0]         result_value;
	logic                      test_flag;
	logic                      status;
	logic                      hold_off_toggle = 1'b0;
	req_t                      port_request;
	int                        send_idle_pct   = 0;
	int                        recv_idle_pct   = 0;
	bitop_scoreboard           tracker;

	wide_bit_manipulation_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.shift_amount (shift_amount),
		.field_start  (field_start),
		.field_width  (field_width),
		.last_operand (last_operand),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.test_flag    (test_flag),
		.status       (status)
	);

	assign port_request = {req_type, operand_a, operand_b, shift_amount,
		field_start, field_width, last_operand};

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Note accepted requests and check accepted results at each edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			tracker.note_request(port_request);
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(result_value, test_flag, status);
	end

	// Drive the output stall: random idling, or a long hold when asked
	initial begin : receiver
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_toggle != hold_seen) begin
				hold_seen = hold_off_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	function automatic req_t make_request(input logic [OPCODE_W-1:0] op,
			input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b, input int sh,
			input int fs, input int fw, input logic last);
		req_t r;
		r.op     = op;
		r.a      = a;
		r.b      = b;
		r.shamt  = SHAMT_W'(sh);
		r.fstart = FSTART_W'(fs);
		r.fwidth = FWIDTH_W'(fw);
		r.last   = last;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return ALL_ONES;
			2:       return TOP_ONLY;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random payload; fields are mostly in range, sometimes anything the ports allow
	function automatic req_t random_request(input logic [OPCODE_W-1:0] op);
		req_t r;
		int   fw;
		r.op = op;
		r.a  = random_word();
		r.b  = random_word();
		if ($urandom_range(0, 1) != 0)
			r.shamt = SHAMT_W'($urandom_range(0, 255));
		else
			r.shamt = SHAMT_W'(int'($urandom_range(0, 140)) - 70);
		if ($urandom_range(0, 4) != 0) begin
			fw       = $urandom_range(1, DATA_W);
			r.fwidth = FWIDTH_W'(fw);
			r.fstart = FSTART_W'($urandom_range(0, DATA_W - fw));
		end else begin
			r.fwidth = FWIDTH_W'($urandom_range(0, 127));
			r.fstart = FSTART_W'($urandom);
		end
		r.last = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// Offer one request after a random gap; hold it until accepted
	task automatic offer_request(input req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= r.op;
		operand_a    <= r.a;
		operand_b    <= r.b;
		shift_amount <= r.shamt;
		field_start  <= r.fstart;
		field_width  <= r.fwidth;
		last_operand <= r.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed fold runs and single ops, plus broken runs and unknown codes
	task automatic random_traffic(input int count);
		int   sent;
		int   pick;
		int   run_len;
		req_t r;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				run_len = $urandom_range(1, 6);
				for (int i = 0; i < run_len; i++) begin
					if ($urandom_range(0, 4) == 0) begin
						offer_request(random_request(OPCODE_W'($urandom_range(OP_NOT, OP_REPLACE))));
						sent++;
					end
					r      = random_request(OPCODE_W'($urandom_range(OP_AND, OP_TEST)));
					r.last = (i == run_len - 1);
					offer_request(r);
					sent++;
				end
			end else if (pick < 90) begin
				offer_request(random_request(OPCODE_W'($urandom_range(OP_NOT, OP_REPLACE))));
				sent++;
			end else if (pick < 96) begin
				offer_request(random_request(OPCODE_W'($urandom_range(OP_AND, OP_TEST))));
				sent++;
			end else begin
				offer_request(random_request(OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))));
			end
		end
	endtask

	initial begin : stimulus
		tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fold runs, mixed runs, interleaved ops, count and field extremes
		offer_request(make_request(OP_AND, ALL_ONES, '0, 0, 0, 1, 1'b1));
		offer_request(make_request(OP_AND, 64'hF0F0_F0F0_F0F0_F0F0, '0, 0, 0, 1, 1'b0));
		offer_request(make_request(OP_OR, 64'h0000_FFFF_0000_FFFF, '0, 0, 0, 1, 1'b0));
		offer_request(make_request(OP_NOT, '0, ALL_ONES, 0, 0, 1, 1'b1));
		offer_request(make_request(OP_UNUSED_LO, ALL_ONES, ALL_ONES, 0, 0, 1, 1'b1));
		offer_request(make_request(OP_XOR, ALL_ONES, '0, 0, 0, 1, 1'b1));
		offer_request(make_request(OP_TEST, 64'h5555_5555_5555_5555, '0, 0, 0, 1, 1'b0));
		offer_request(make_request(OP_TEST, 64'hAAAA_AAAA_AAAA_AAAA, '0, 0, 0, 1, 1'b1));
		offer_request(make_request(OP_TEST, TOP_ONLY, '0, 0, 0, 1, 1'b1));
		offer_request(make_request(OP_LSHIFT, ALL_ONES, '0, 127, 0, 1, 1'b0));
		offer_request(make_request(OP_LSHIFT, ALL_ONES, '0, -128, 0, 1, 1'b0));
		offer_request(make_request(OP_LSHIFT, 64'h0123_4567_89AB_CDEF, '0, 63, 0, 1, 1'b0));
		offer_request(make_request(OP_RSHIFT, ALL_ONES, '0, 64, 0, 1, 1'b0));
		offer_request(make_request(OP_RSHIFT, 64'h0123_4567_89AB_CDEF, '0, -1, 0, 1, 1'b0));
		offer_request(make_request(OP_ARSHIFT, TOP_ONLY, '0, 127, 0, 1, 1'b0));
		offer_request(make_request(OP_ARSHIFT, ALL_ONES, '0, -5, 0, 1, 1'b0));
		offer_request(make_request(OP_ARSHIFT, 64'h8000_0000_0000_0001, '0, 63, 0, 1, 1'b0));
		offer_request(make_request(OP_LROT, 64'h0123_4567_89AB_CDEF, '0, 0, 0, 1, 1'b0));
		offer_request(make_request(OP_LROT, 64'h0123_4567_89AB_CDEF, '0, 64, 0, 1, 1'b0));
		offer_request(make_request(OP_RROT, 64'h0123_4567_89AB_CDEF, '0, -1, 0, 1, 1'b0));
		offer_request(make_request(OP_EXTRACT, 64'h0123_4567_89AB_CDEF, '0, 0, 0, 64, 1'b0));
		offer_request(make_request(OP_EXTRACT, ALL_ONES, '0, 0, 63, 1, 1'b0));
		offer_request(make_request(OP_EXTRACT, ALL_ONES, '0, 0, 60, 5, 1'b0));
		offer_request(make_request(OP_EXTRACT, ALL_ONES, '0, 0, 0, 0, 1'b0));
		offer_request(make_request(OP_REPLACE, 64'h0123_4567_89AB_CDEF, ALL_ONES, 0, 32, 32, 1'b0));
		offer_request(make_request(OP_REPLACE, ALL_ONES, ALL_ONES, 0, 63, 127, 1'b0));
		offer_request(make_request(OP_UNUSED_HI, '0, '0, 0, 0, 0, 1'b0));

		// Random: slow receiver, then slow sender after a full drain
		send_idle_pct = 17;
		recv_idle_pct = 84;
		random_traffic(PHASE_ITEMS);
		wait_for_results();
		send_idle_pct = 84;
		recv_idle_pct = 17;
		random_traffic(PHASE_ITEMS);

		// No idling; start with a long output hold so the unit backs up
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		hold_off_toggle <= ~hold_off_toggle;
		random_traffic(PHASE_ITEMS);
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: all twelve ops, fold runs, count and field extremes.",
			tracker.requests_seen);
		$display("Checked %0d results under three idle mixes and a long output hold.",
			tracker.results_checked);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("[wide_bit_manipulation_unit] OK");
		end else begin
			$display("[wide_bit_manipulation_unit] ERROR");
		end
		$finish;
	end

	// Bound the run in case the handshake hangs
	initial begin : watchdog
		#2_000_000;
		$display("[wide_bit_manipulation_unit] ERROR");
		$finish;
	end

endmodule

>>> wide_bit_manipulation_unit.f
hw/rtl/wbmu_pkg.sv
hw/rtl/wbmu_alu.sv
hw/rtl/wbmu_reduce.sv
hw/rtl/wide_bit_manipulation_unit.sv
bench/tb_wide_bit_manipulation_unit.sv
